### sv/cvr_pkg.sv
// Shared types, clause token table and character helpers for the credential redactor.
package cvr_pkg;

   // Token kinds of the clause pattern
   localparam logic [2:0] K_LIT = 3'd0;  // literal, case-folded
   localparam logic [2:0] K_S   = 3'd1;  // whitespace
   localparam logic [2:0] K_W   = 3'd2;  // word character
   localparam logic [2:0] K_Q   = 3'd3;  // either quote
   localparam logic [2:0] K_C   = 3'd4;  // colon or equals
   localparam logic [2:0] K_D   = 3'd5;  // dot, underscore or dash
   localparam logic [2:0] K_ACC = 3'd6;  // end of an alternative

   // Quantifiers
   localparam logic [1:0] Q_ONE  = 2'd0;
   localparam logic [1:0] Q_OPT  = 2'd1;
   localparam logic [1:0] Q_STAR = 2'd2;
   localparam logic [1:0] Q_PLUS = 2'd3;

   // Characters with a role in the value scanner and the emitter
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_MASK      = 8'h2A;

   // Mask run after an opening quote
   localparam int unsigned MASK_BEATS = 4;
   localparam int unsigned BEAT_W     = $clog2(MASK_BEATS + 1);

   // Number of token positions over all nine alternatives
   localparam int unsigned NTOK = 157;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [1:0] quant;
   } tok_type;

   // One burst of results handed from the request stage to the emitter
   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       stars;
      logic       last;
      logic       masked;
   } burst_type;

   function automatic tok_type t_lit(input logic [7:0] c);
      t_lit = '{kind: K_LIT, ch: c, quant: Q_ONE};
   endfunction

   function automatic tok_type t_lq(input logic [7:0] c, input logic [1:0] q);
      t_lq = '{kind: K_LIT, ch: c, quant: q};
   endfunction

   function automatic tok_type t_cls(input logic [2:0] k, input logic [1:0] q);
      t_cls = '{kind: k, ch: 8'h00, quant: q};
   endfunction

   // Flattened alternatives, each closed by an end token
   localparam tok_type TOK_TABLE [NTOK] = '{
      // password\s*:\s*Q
      t_lit("p"), t_lit("a"), t_lit("s"), t_lit("s"), t_lit("w"), t_lit("o"),
      t_lit("r"), t_lit("d"), t_cls(K_S, Q_STAR), t_lit(":"), t_cls(K_S, Q_STAR),
      t_cls(K_Q, Q_ONE), t_cls(K_ACC, Q_ONE),
      // pas+word\s+to\s*Q
      t_lit("p"), t_lit("a"), t_lq("s", Q_PLUS), t_lit("w"), t_lit("o"), t_lit("r"),
      t_lit("d"), t_cls(K_S, Q_PLUS), t_lit("t"), t_lit("o"), t_cls(K_S, Q_STAR),
      t_cls(K_Q, Q_ONE), t_cls(K_ACC, Q_ONE),
      // re?pl?ac?e?\s*Q
      t_lit("r"), t_lq("e", Q_OPT), t_lit("p"), t_lq("l", Q_OPT), t_lit("a"),
      t_lq("c", Q_OPT), t_lq("e", Q_OPT), t_cls(K_S, Q_STAR), t_cls(K_Q, Q_ONE),
      t_cls(K_ACC, Q_ONE),
      // identified\s+by\s*Q
      t_lit("i"), t_lit("d"), t_lit("e"), t_lit("n"), t_lit("t"), t_lit("i"),
      t_lit("f"), t_lit("i"), t_lit("e"), t_lit("d"), t_cls(K_S, Q_PLUS),
      t_lit("b"), t_lit("y"), t_cls(K_S, Q_STAR), t_cls(K_Q, Q_ONE),
      t_cls(K_ACC, Q_ONE),
      // pas+word\s+for\s+\w+\s+to\s*Q
      t_lit("p"), t_lit("a"), t_lq("s", Q_PLUS), t_lit("w"), t_lit("o"), t_lit("r"),
      t_lit("d"), t_cls(K_S, Q_PLUS), t_lit("f"), t_lit("o"), t_lit("r"),
      t_cls(K_S, Q_PLUS), t_cls(K_W, Q_PLUS), t_cls(K_S, Q_PLUS), t_lit("t"),
      t_lit("o"), t_cls(K_S, Q_STAR), t_cls(K_Q, Q_ONE), t_cls(K_ACC, Q_ONE),
      // Q? aws, access, key joined by underscores, Q?\s*[:=]\s*Q
      t_cls(K_Q, Q_OPT), t_lit("a"), t_lit("w"), t_lit("s"), t_lit("_"),
      t_lit("a"), t_lit("c"), t_lit("c"), t_lit("e"), t_lit("s"), t_lit("s"),
      t_lit("_"), t_lit("k"), t_lit("e"), t_lit("y"), t_cls(K_Q, Q_OPT),
      t_cls(K_S, Q_STAR), t_cls(K_C, Q_ONE), t_cls(K_S, Q_STAR), t_cls(K_Q, Q_ONE),
      t_cls(K_ACC, Q_ONE),
      // Q? aws, secret, key joined by underscores, Q?\s*[:=]\s*Q
      t_cls(K_Q, Q_OPT), t_lit("a"), t_lit("w"), t_lit("s"), t_lit("_"),
      t_lit("s"), t_lit("e"), t_lit("c"), t_lit("r"), t_lit("e"), t_lit("t"),
      t_lit("_"), t_lit("k"), t_lit("e"), t_lit("y"), t_cls(K_Q, Q_OPT),
      t_cls(K_S, Q_STAR), t_cls(K_C, Q_ONE), t_cls(K_S, Q_STAR), t_cls(K_Q, Q_ONE),
      t_cls(K_ACC, Q_ONE),
      // Q?aws[._-]?access[._-]?keyQ?\s+to\s*Q
      t_cls(K_Q, Q_OPT), t_lit("a"), t_lit("w"), t_lit("s"), t_cls(K_D, Q_OPT),
      t_lit("a"), t_lit("c"), t_lit("c"), t_lit("e"), t_lit("s"), t_lit("s"),
      t_cls(K_D, Q_OPT), t_lit("k"), t_lit("e"), t_lit("y"), t_cls(K_Q, Q_OPT),
      t_cls(K_S, Q_PLUS), t_lit("t"), t_lit("o"), t_cls(K_S, Q_STAR),
      t_cls(K_Q, Q_ONE), t_cls(K_ACC, Q_ONE),
      // Q?aws[._-]?secret[._-]?keyQ?\s+to\s*Q
      t_cls(K_Q, Q_OPT), t_lit("a"), t_lit("w"), t_lit("s"), t_cls(K_D, Q_OPT),
      t_lit("s"), t_lit("e"), t_lit("c"), t_lit("r"), t_lit("e"), t_lit("t"),
      t_cls(K_D, Q_OPT), t_lit("k"), t_lit("e"), t_lit("y"), t_cls(K_Q, Q_OPT),
      t_cls(K_S, Q_PLUS), t_lit("t"), t_lit("o"), t_cls(K_S, Q_STAR),
      t_cls(K_Q, Q_ONE), t_cls(K_ACC, Q_ONE)
   };

   // Does byte c satisfy token t; folding applies to A-Z only
   function automatic logic tok_match(input tok_type t, input logic [7:0] c);
      logic [7:0] f;
      logic       r;
      f = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
      case (t.kind)
         K_LIT: r = (f == t.ch);
         K_S:   r = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
         K_W:   r = (f >= 8'h61 && f <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
                    (c == 8'h5F);
         K_Q:   r = (c == CH_SQUOTE) || (c == CH_DQUOTE);
         K_C:   r = (c == 8'h3A) || (c == 8'h3D);
         K_D:   r = (c == 8'h2E) || (c == 8'h5F) || (c == 8'h2D);
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

### sv/cvr_matcher.sv
// Bit-parallel clause matcher: one active-position vector updated per byte.
module cvr_matcher
   import cvr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,    // advance on in_byte
   input  logic       clear,     // end of message, drop all partial matches
   input  logic [7:0] in_byte,
   output logic       hit        // a clause completes on in_byte
);

   logic [NTOK-1:0] state_ff;
   logic [NTOK-1:0] state_in;

   logic [NTOK-1:0] start_mask;
   logic [NTOK-1:0] skip_mask;
   logic [NTOK-1:0] rep_mask;
   logic [NTOK-1:0] adv_mask;
   logic [NTOK-1:0] acc_mask;
   logic [NTOK-1:0] cur;
   logic [NTOK-1:0] match;
   logic [NTOK-1:0] nxt;

   // Position masks from the token table (constant after elaboration)
   always_comb begin
      for (int k = 0; k < NTOK; k++) begin
         acc_mask[k]   = (TOK_TABLE[k].kind == K_ACC);
         skip_mask[k]  = !acc_mask[k] &&
                         (TOK_TABLE[k].quant == Q_OPT || TOK_TABLE[k].quant == Q_STAR);
         rep_mask[k]   = (TOK_TABLE[k].quant == Q_STAR || TOK_TABLE[k].quant == Q_PLUS);
         adv_mask[k]   = (TOK_TABLE[k].quant != Q_STAR);
         start_mask[k] = (k == 0) ? 1'b1 : (TOK_TABLE[(k == 0) ? 0 : k - 1].kind == K_ACC);
      end
   end

   // Active positions plus a fresh start of every alternative, then skip optionals
   always_comb begin
      cur = state_ff | start_mask;
      for (int k = 1; k < NTOK; k++) begin
         cur[k] = cur[k] | (cur[k-1] & skip_mask[k-1]);
      end
   end

   // Per-position character test
   always_comb begin
      for (int k = 0; k < NTOK; k++) begin
         match[k] = cur[k] && !acc_mask[k] && tok_match(TOK_TABLE[k], in_byte);
      end
   end

   // Shift matched positions forward, keep repeating ones, then skip optionals
   always_comb begin
      nxt[0] = match[0] & rep_mask[0];
      for (int k = 1; k < NTOK; k++) begin
         nxt[k] = (match[k] & rep_mask[k]) | (match[k-1] & adv_mask[k-1]);
      end
      for (int k = 1; k < NTOK; k++) begin
         nxt[k] = nxt[k] | (nxt[k-1] & skip_mask[k-1]);
      end
   end

   assign hit = |(nxt & acc_mask);

   // Next state
   always_comb begin
      state_in = state_ff;
      if (clear || (enable && hit)) begin
         state_in = '0;
      end else if (enable) begin
         state_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/cvr_emitter.sv
// Result register that plays out one burst: a byte or end marker, then optional mask run.
module cvr_emitter
   import cvr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,       // take burst this cycle
   input  burst_type  burst,
   output logic       load_ok,    // free now, or last beat leaves this cycle
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic [1:0] rsp_tuser,  // [0] out_valid, [1] any_masked
   output logic       rsp_tlast   // out_last
);

   logic              busy_ff;
   logic              busy_in;
   logic [BEAT_W-1:0] beat_ff;
   logic [BEAT_W-1:0] beat_in;
   burst_type         burst_ff;
   burst_type         burst_in;

   logic final_beat;
   logic take;

   // Current beat decode
   assign final_beat = burst_ff.stars ? (beat_ff == BEAT_W'(MASK_BEATS)) : 1'b1;
   assign take       = busy_ff && rsp_tready;
   assign load_ok    = !busy_ff || (take && final_beat);

   assign rsp_tvalid   = busy_ff;
   assign rsp_tdata    = (beat_ff == '0) ? burst_ff.data : CH_MASK;
   assign rsp_tuser[0] = (beat_ff == '0) ? burst_ff.has_byte : 1'b1;
   assign rsp_tlast    = burst_ff.last && final_beat;
   assign rsp_tuser[1] = burst_ff.masked && burst_ff.last && final_beat;

   // Beat sequencing
   always_comb begin
      busy_in  = busy_ff;
      beat_in  = beat_ff;
      burst_in = burst_ff;
      if (load) begin
         busy_in  = 1'b1;
         beat_in  = '0;
         burst_in = burst;
      end else if (take) begin
         if (final_beat) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + BEAT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff  <= beat_in;
      burst_ff <= burst_in;
   end

endmodule

### sv/credential_value_redactor.sv
// Top level of the credential value redactor: request register, value scanner, result stage.
// Order: an accepted request is held in the request register, then loaded into the result
// register, which presents it on the response; a busy result register stalls the load.
// Throughput: one byte per cycle while the result register can take it; a byte that
// opens a value holds the result register for its quote and four asterisks; a later
// byte that produces output waits for it, swallowed value bytes keep flowing.
// Reset: synchronous, clears the matcher, value tracking and both stage valids; no sweep.
module credential_value_redactor
   import cvr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] out_valid, [1] any_masked
   output logic       rsp_tlast    // out_last
);

   // Request register
   logic       req_valid_ff;
   logic       req_valid_in;
   logic [7:0] req_byte_ff;
   logic       req_last_ff;

   // Value tracking state
   logic in_value_ff,   in_value_in;
   logic escape_ff,     escape_in;
   logic dquote_ff,     dquote_in;
   logic masked_ff,     masked_in;

   logic       hit;
   logic       stars;
   logic       emit_byte;
   logic       need_load;
   logic       load_ok;
   logic       consume;
   logic [7:0] open_quote;
   burst_type  burst;

   cvr_matcher u_matcher (
      .clock   (clock),
      .reset   (reset),
      .enable  (consume && !in_value_ff),
      .clear   (consume && req_last_ff),
      .in_byte (req_byte_ff),
      .hit     (hit)
   );

   // Decide what this byte produces
   assign open_quote = dquote_ff ? CH_DQUOTE : CH_SQUOTE;
   assign stars      = !in_value_ff && hit;
   assign emit_byte  = in_value_ff ? (!escape_ff && req_byte_ff != CH_BACKSLASH &&
                                      req_byte_ff == open_quote)
                                   : 1'b1;
   assign need_load  = emit_byte || req_last_ff;
   assign consume    = req_valid_ff && (!need_load || load_ok);
   assign req_tready = !req_valid_ff || consume;

   always_comb begin
      burst.data     = emit_byte ? req_byte_ff : 8'h00;
      burst.has_byte = emit_byte;
      burst.stars    = stars;
      burst.last     = req_last_ff;
      burst.masked   = masked_ff || stars;
   end

   cvr_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (consume && need_load),
      .burst      (burst),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Value scanner next state
   always_comb begin
      in_value_in = in_value_ff;
      escape_in   = escape_ff;
      dquote_in   = dquote_ff;
      masked_in   = masked_ff;
      if (consume) begin
         if (in_value_ff) begin
            if (escape_ff) begin
               escape_in = 1'b0;
            end else if (req_byte_ff == CH_BACKSLASH) begin
               escape_in = 1'b1;
            end else if (req_byte_ff == open_quote) begin
               in_value_in = 1'b0;
            end
         end else if (hit) begin
            in_value_in = 1'b1;
            escape_in   = 1'b0;
            dquote_in   = (req_byte_ff == CH_DQUOTE);
            masked_in   = 1'b1;
         end
         // end of message starts the next one clean
         if (req_last_ff) begin
            in_value_in = 1'b0;
            escape_in   = 1'b0;
            dquote_in   = 1'b0;
            masked_in   = 1'b0;
         end
      end
   end

   // Request register valid
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (consume) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         in_value_ff  <= 1'b0;
         escape_ff    <= 1'b0;
         dquote_ff    <= 1'b0;
         masked_ff    <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         in_value_ff  <= in_value_in;
         escape_ff    <= escape_in;
         dquote_ff    <= dquote_in;
         masked_ff    <= masked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_byte_ff <= req_tdata;
         req_last_ff <= req_tlast;
      end
   end

   // A bare end marker only closes a message
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("bare end marker without last");

   // The masked flag rides on the final result only
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("any_masked set on a non-final result");

   // A clause hit in mid-message enters the value
   assert property (@(posedge clock) disable iff (reset)
      (consume && stars && !req_last_ff) |=> in_value_ff)
      else $error("clause hit did not open a value");

endmodule

### dv/credential_value_redactor_tb.sv
// Self-checking testbench for the credential value redactor: byte stream in, redacted stream out.
module credential_value_redactor_tb;

   localparam int MAXTOK       = 192;
   localparam int NALT         = 9;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 100;

   localparam logic [7:0] SQUOTE    = 8'h27;
   localparam logic [7:0] DQUOTE    = 8'h22;
   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam logic [7:0] STAR      = 8'h2A;

   typedef enum logic [2:0] {
      TK_LIT, TK_SPACE, TK_WORD, TK_QUOTE, TK_COLON, TK_DOT, TK_ACCEPT
   } tok_kind_type;

   typedef enum logic [1:0] {QN_ONE, QN_OPT, QN_STAR, QN_PLUS} quant_type;

   // One redacted output beat
   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last;
      logic       masked;
   } redacted_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;    // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [1:0] rsp_tuser;            // [0] out_valid, [1] any_masked
   logic       rsp_tlast;            // out_last

   bit         hold_request  = 1'b0;
   bit         sender_fast   = 1'b0;
   bit         receiver_fast = 1'b0;
   int         cycles        = 0;
   logic [7:0] msg_q[$];

   credential_value_redactor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Predicts the redacted stream and checks the block's responses against it
   class redaction_scoreboard;
      tok_kind_type     tok_kind[MAXTOK];
      logic [7:0]       tok_char[MAXTOK];
      quant_type        tok_quant[MAXTOK];
      bit [MAXTOK-1:0]  start_set;
      bit [MAXTOK-1:0]  accept_set;
      bit [MAXTOK-1:0]  active;
      bit               in_value;
      bit               escape_pending;
      bit               quote_double;
      bit               masked_seen;
      redacted_type     redacted_q[$];
      int unsigned      failures;

      function new();
         failures = 0;
         build_tokens();
         clear_message();
      endfunction

      // Flatten all clause alternatives into one token list
      function void build_tokens();
         string      clause_src[NALT];
         string      aws_head;
         string      s;
         int         n;
         int         i;
         logic [7:0] c;
         aws_head = "Q?aws_";
         clause_src[0] = "passwordS*:S*Q";
         clause_src[1] = "pas+wordS+toS*Q";
         clause_src[2] = "re?pl?ac?e?S*Q";
         clause_src[3] = "identifiedS+byS*Q";
         clause_src[4] = "pas+wordS+forS+W+S+toS*Q";
         clause_src[5] = {aws_head, "access_keyQ?S*CS*Q"};
         clause_src[6] = {aws_head, "secret_keyQ?S*CS*Q"};
         clause_src[7] = "Q?awsD?accessD?keyQ?S+toS*Q";
         clause_src[8] = "Q?awsD?secretD?keyQ?S+toS*Q";
         n = 0;
         start_set = '0;
         accept_set = '0;
         for (int k = 0; k < MAXTOK; k++) begin
            tok_kind[k] = TK_LIT;
            tok_char[k] = 8'h00;
            tok_quant[k] = QN_ONE;
         end
         for (int a = 0; a < NALT; a++) begin
            s = clause_src[a];
            start_set[n] = 1'b1;
            i = 0;
            while (i < s.len() && n + 1 < MAXTOK) begin
               c = s[i];
               i++;
               tok_char[n] = c;
               if (c == "S") tok_kind[n] = TK_SPACE;
               else if (c == "W") tok_kind[n] = TK_WORD;
               else if (c == "Q") tok_kind[n] = TK_QUOTE;
               else if (c == "C") tok_kind[n] = TK_COLON;
               else if (c == "D") tok_kind[n] = TK_DOT;
               else tok_kind[n] = TK_LIT;
               tok_quant[n] = QN_ONE;
               if (i < s.len()) begin
                  if (s[i] == "?") begin
                     tok_quant[n] = QN_OPT;
                     i++;
                  end else if (s[i] == "*") begin
                     tok_quant[n] = QN_STAR;
                     i++;
                  end else if (s[i] == "+") begin
                     tok_quant[n] = QN_PLUS;
                     i++;
                  end
               end
               n++;
            end
            tok_kind[n] = TK_ACCEPT;
            accept_set[n] = 1'b1;
            n++;
         end
      endfunction

      function void clear_message();
         active = '0;
         in_value = 1'b0;
         escape_pending = 1'b0;
         quote_double = 1'b0;
         masked_seen = 1'b0;
      endfunction

      function bit byte_fits(int k, logic [7:0] c);
         logic [7:0] f;
         f = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
         case (tok_kind[k])
            TK_LIT:   return f == tok_char[k];
            TK_SPACE: return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
            TK_WORD:  return (f >= 8'h61 && f <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
                             c == 8'h5F;
            TK_QUOTE: return c == SQUOTE || c == DQUOTE;
            TK_COLON: return c == 8'h3A || c == 8'h3D;
            TK_DOT:   return c == 8'h2E || c == 8'h5F || c == 8'h2D;
            default:  return 1'b0;
         endcase
      endfunction

      // Optional and starred tokens may be skipped; ascending order chains the skips
      function bit [MAXTOK-1:0] close_optional(bit [MAXTOK-1:0] s);
         for (int k = 0; k < MAXTOK - 1; k++)
            if (s[k] && tok_kind[k] != TK_ACCEPT &&
                (tok_quant[k] == QN_OPT || tok_quant[k] == QN_STAR))
               s[k+1] = 1'b1;
         return s;
      endfunction

      // Step every alternative at once; true when a clause completes
      function bit advance_matcher(logic [7:0] c);
         bit [MAXTOK-1:0] cur;
         bit [MAXTOK-1:0] nxt;
         bit              hit;
         cur = close_optional(active | start_set);
         nxt = '0;
         for (int k = 0; k < MAXTOK; k++) begin
            if (cur[k] && tok_kind[k] != TK_ACCEPT && byte_fits(k, c)) begin
               if (tok_quant[k] == QN_STAR || tok_quant[k] == QN_PLUS) nxt[k] = 1'b1;
               if (tok_quant[k] != QN_STAR && k + 1 < MAXTOK) nxt[k+1] = 1'b1;
            end
         end
         nxt = close_optional(nxt);
         hit = |(nxt & accept_set);
         active = hit ? '0 : nxt;
         return hit;
      endfunction

      function void add_beat(logic [7:0] b, logic has_byte);
         redacted_type r;
         r = '{data: b, has_byte: has_byte, last: 1'b0, masked: 1'b0};
         redacted_q = {redacted_q, r};
      endfunction

      // Accepted request: queue the beats it must produce
      function void note_request(logic [7:0] c, logic last);
         int           n0;
         redacted_type r;
         n0 = redacted_q.size();
         if (in_value) begin
            if (escape_pending) begin
               escape_pending = 1'b0;
            end else if (c == BACKSLASH) begin
               escape_pending = 1'b1;
            end else if (c == (quote_double ? DQUOTE : SQUOTE)) begin
               add_beat(c, 1'b1);
               in_value = 1'b0;
            end
         end else begin
            add_beat(c, 1'b1);
            if (advance_matcher(c)) begin
               repeat (4) add_beat(STAR, 1'b1);
               in_value = 1'b1;
               escape_pending = 1'b0;
               quote_double = (c == DQUOTE);
               masked_seen = 1'b1;
            end
         end
         if (last) begin
            // swallowed final byte still closes the message with a bare marker
            if (redacted_q.size() == n0) add_beat(8'h00, 1'b0);
            r = redacted_q.pop_back();
            r.last = 1'b1;
            r.masked = masked_seen;
            redacted_q = {redacted_q, r};
            clear_message();
         end
      endfunction

      function void check_response(logic [7:0] data, logic [1:0] user, logic last);
         redacted_type want;
         if (redacted_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: unexpected response data %02h valid %0b masked %0b last %0b",
                        data, user[0], user[1], last);
            return;
         end
         want = redacted_q.pop_front();
         if (data !== want.data || user[0] !== want.has_byte || user[1] !== want.masked ||
             last !== want.last) begin
            failures++;
            if (failures <= 10)
               $display(
                  "ERROR: expected %02h valid %0b masked %0b last %0b, got %02h %0b %0b %0b",
                  want.data, want.has_byte, want.masked, want.last,
                  data, user[0], user[1], last);
         end
      endfunction

      function int outstanding();
         return redacted_q.size();
      endfunction
   endclass

   redaction_scoreboard sb;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) @(posedge clock) cycles++;
      $display("Some tests failed");
      $finish;
   end

   // Response side: random backpressure, a long hold on request, check on every transfer
   initial begin
      int hold_left;
      int stall_left;
      int r;
      bit ready;
      hold_left = 0;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else begin
            if ($urandom_range(99) == 0) receiver_fast = !receiver_fast;
            r = $urandom_range(99);
            if (receiver_fast || r < 65) begin
               ready = 1'b1;
            end else if (r < 94) begin
               ready = 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               ready = 1'b0;
               stall_left = $urandom_range(8, 30);
            end
         end
         rsp_tready <= ready;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Offer one request and hold it until the block takes it
   task automatic push_request(logic [7:0] b, logic last);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b, last);
   endtask

   task automatic idle_sender(int n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom_range(0, 255));
         req_tlast <= 1'($urandom_range(0, 1));
         repeat (n - 1) @(negedge clock);
      end
   endtask

   function automatic int sender_gap();
      int r;
      if (sender_fast) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_message(bit steady);
      sender_fast = steady || ($urandom_range(3) == 0);
      for (int i = 0; i < msg_q.size(); i++) begin
         push_request(msg_q[i], i == msg_q.size() - 1);
         idle_sender(sender_gap());
      end
      msg_q.delete();
   endtask

   // Stop offering and wait until every predicted beat has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Append one byte to the message under construction
   task automatic put_byte(logic [7:0] b);
      msg_q = {msg_q, b};
   endtask

   task automatic put_raw(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   // Literal text with random letter case
   task automatic put_text(string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1)) c = c - 8'h20;
         put_byte(c);
      end
   endtask

   task automatic put_opt(string s);
      if ($urandom_range(1)) put_text(s);
   endtask

   task automatic put_space(int lo, int hi);
      int r;
      repeat ($urandom_range(lo, hi)) begin
         r = $urandom_range(0, 5);
         put_byte(r == 5 ? 8'h20 : 8'h09 + r[7:0]);
      end
   endtask

   function automatic logic [7:0] any_quote();
      return $urandom_range(1) ? DQUOTE : SQUOTE;
   endfunction

   task automatic put_opt_quote();
      if ($urandom_range(1)) put_byte(any_quote());
   endtask

   task automatic put_separator();
      int r;
      r = $urandom_range(3);
      if (r == 1) put_byte(8'h2E);
      else if (r == 2) put_byte(8'h5F);
      else if (r == 3) put_byte(8'h2D);
   endtask

   task automatic put_password_head();
      put_text("pa");
      repeat ($urandom_range(1, 3)) put_text("s");
      put_text("word");
   endtask

   task automatic put_word();
      int r;
      repeat ($urandom_range(1, 4)) begin
         r = $urandom_range(0, 62);
         if (r < 26) put_byte(8'h61 + r[7:0]);
         else if (r < 52) put_byte(8'h41 + r[7:0] - 8'd26);
         else if (r < 62) put_byte(8'h30 + r[7:0] - 8'd52);
         else put_byte(8'h5F);
      end
   endtask

   // One clause alternative up to, not including, its opening quote
   task automatic put_clause(int alt);
      case (alt)
         0: begin
            put_text("password");
            put_space(0, 2);
            put_text(":");
            put_space(0, 2);
         end
         1: begin
            put_password_head();
            put_space(1, 2);
            put_text("to");
            put_space(0, 2);
         end
         2: begin
            put_text("r");
            put_opt("e");
            put_text("p");
            put_opt("l");
            put_text("a");
            put_opt("c");
            put_opt("e");
            put_space(0, 2);
         end
         3: begin
            put_text("identified");
            put_space(1, 2);
            put_text("by");
            put_space(0, 2);
         end
         4: begin
            put_password_head();
            put_space(1, 2);
            put_text("for");
            put_space(1, 2);
            put_word();
            put_space(1, 2);
            put_text("to");
            put_space(0, 2);
         end
         5, 6: begin
            put_opt_quote();
            put_text("aws_");
            put_text(alt == 5 ? "access" : "secret");
            put_text("_key");
            put_opt_quote();
            put_space(0, 2);
            put_byte($urandom_range(1) ? 8'h3A : 8'h3D);
            put_space(0, 2);
         end
         default: begin
            put_opt_quote();
            put_text("aws");
            put_separator();
            put_text(alt == 7 ? "access" : "secret");
            put_separator();
            put_text("key");
            put_opt_quote();
            put_space(1, 2);
            put_text("to");
            put_space(0, 2);
         end
      endcase
   endtask

   // Secret value with escapes; usually closed by the opening quote
   task automatic put_value(logic [7:0] q);
      logic [7:0] c;
      int         r;
      repeat ($urandom_range(0, 6)) begin
         r = $urandom_range(9);
         if (r == 0) begin
            put_byte(BACKSLASH);
            put_byte(8'($urandom_range(0, 255)));
         end else begin
            c = (r == 1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(8'h20, 8'h7E));
            if (c == q || c == BACKSLASH) c = 8'h78;
            put_byte(c);
         end
      end
      if ($urandom_range(6) != 0) put_byte(q);
   endtask

   task automatic build_message(int pieces);
      int         r;
      int         first;
      int         idx;
      logic [7:0] q;
      repeat (pieces) begin
         r = $urandom_range(9);
         if (r < 6) begin
            put_clause($urandom_range(0, NALT - 1));
            q = any_quote();
            put_byte(q);
            put_value(q);
         end else if (r < 8) begin
            // clause with one byte corrupted or cut short
            first = msg_q.size();
            put_clause($urandom_range(0, NALT - 1));
            idx = $urandom_range(first, msg_q.size() - 1);
            if ($urandom_range(1)) msg_q[idx] = 8'($urandom_range(0, 255));
            else while (msg_q.size() > idx) void'(msg_q.pop_back());
            put_byte(any_quote());
         end else begin
            repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      int random_bytes;
      int msg_count;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // shortest clause, escaped quote inside the value, text after the close
      put_raw("rpa\"a\\\"b\"z");
      send_message(1'b0);
      // message ends inside a value: swallowed last byte gives a bare end marker
      put_raw("RpA'x");
      send_message(1'b0);
      // high bytes and zero, nothing masked
      put_byte(8'hFF);
      put_byte(8'h00);
      send_message(1'b0);
      // last byte opens a value: end flag lands on the final asterisk
      put_raw("rpa'");
      send_message(1'b0);
      // lone quote
      put_raw("'");
      send_message(1'b0);
      wait_drained();

      random_bytes = 0;
      msg_count = 0;
      while (random_bytes < RANDOM_BYTES) begin
         if (msg_count == 2) begin
            // receiver holds off while a dense message streams in
            build_message(4);
            hold_request = 1'b1;
            random_bytes += msg_q.size();
            send_message(1'b1);
            wait_drained();
         end else begin
            build_message($urandom_range(1, 3));
            random_bytes += msg_q.size();
            send_message(1'b0);
            if (msg_count == 6) wait_drained();
         end
         msg_count++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
sv/cvr_pkg.sv
sv/cvr_matcher.sv
sv/cvr_emitter.sv
sv/credential_value_redactor.sv
dv/credential_value_redactor_tb.sv
